// File: src/fp8c_pkg.sv
`default_nettype none

package fp8c_pkg;

    typedef enum logic [1:0] {
        ACT_E4M3_TO_FP32 = 2'd0,
        ACT_E5M2_TO_FP32 = 2'd1,
        ACT_FP32_TO_E4M3 = 2'd2,
        ACT_FP32_TO_E5M2 = 2'd3
    } action_t;

    localparam logic [31:0] FP32_QNAN   = 32'h7fc0_0000;
    localparam logic [31:0] FP32_INF    = 32'h7f80_0000;
    localparam logic [7:0]  E4M3_INF    = 8'h78;
    localparam logic [7:0]  E5M2_INF    = 8'h7c;
    localparam logic [7:0]  FP8_NAN     = 8'h7f;
    localparam logic [22:0] FP32_FRAC0  = 23'd0;

    localparam logic signed [9:0] FP32_BIAS = 10'sd127;
    localparam logic signed [9:0] E4M3_BIAS = 10'sd7;
    localparam logic signed [9:0] E5M2_BIAS = 10'sd15;
    localparam logic signed [9:0] E4M3_EMAX = 10'sd15;
    localparam logic signed [9:0] E5M2_EMAX = 10'sd31;
    // Lowest unbiased-to-FP8 exponent that can still round to a nonzero subnormal
    localparam logic signed [9:0] E4M3_EMIN = -10'sd3;
    localparam logic signed [9:0] E5M2_EMIN = -10'sd2;

    // Right shift of the 24-bit significand for a normal FP8 result
    localparam logic [4:0] E4M3_NSHIFT = 5'd20;
    localparam logic [4:0] E5M2_NSHIFT = 5'd21;

    // FP32 exponent = FP8 exponent + (127 - bias)
    localparam logic [7:0] E4M3_WOFS = 8'd120;
    localparam logic [7:0] E5M2_WOFS = 8'd112;

    // Stage 1 -> stage 2 payload
    typedef struct packed {
        logic        done;    // word already final
        logic [31:0] word;
        logic        narrow;  // FP32 to FP8
        logic        e5m2;
        logic        sign;
        logic [4:0]  expo;    // FP8 exponent field (widening)
        logic [2:0]  man;     // FP8 fraction, left aligned (widening)
        logic [23:0] sig;     // FP32 significand with hidden bit (narrowing)
        logic [4:0]  shamt;   // right shift of sig (narrowing)
        logic [4:0]  base;    // FP8 exponent field minus one, or zero
    } dec_t;

    // Stage 2 -> stage 3 payload
    typedef struct packed {
        logic        done;
        logic [31:0] word;
        logic        narrow;
        logic        e5m2;
        logic        sign;
        logic [3:0]  q;
        logic        guard;
        logic        sticky;
        logic [4:0]  base;
    } shf_t;

endpackage

`default_nettype wire

// File: src/fp8c_decode.sv
`default_nettype none

module fp8c_decode
    import fp8c_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire action_t     in_action,
    input  wire logic [31:0] in_operand,
    output logic             out_valid,
    input  wire logic        out_ready,
    output dec_t             out_data
);

    logic valid_reg;
    dec_t data_reg;
    dec_t data_next;

    always_comb begin
        logic              narrow;
        logic              e5m2;
        logic [7:0]        exp8;
        logic [22:0]       frac;
        logic signed [9:0] bias;
        logic signed [9:0] emax;
        logic signed [9:0] emin;
        logic signed [9:0] ef;
        logic signed [9:0] ext;
        logic [7:0]        inf8;
        logic [4:0]        nshift;
        logic [4:0]        fe;
        logic [2:0]        fm;
        logic              fe_max;

        unique case (in_action)
            ACT_E4M3_TO_FP32: begin narrow = 1'b0; e5m2 = 1'b0; end
            ACT_E5M2_TO_FP32: begin narrow = 1'b0; e5m2 = 1'b1; end
            ACT_FP32_TO_E4M3: begin narrow = 1'b1; e5m2 = 1'b0; end
            ACT_FP32_TO_E5M2: begin narrow = 1'b1; e5m2 = 1'b1; end
            default:          begin narrow = 1'b0; e5m2 = 1'b0; end
        endcase

        exp8   = in_operand[30:23];
        frac   = in_operand[22:0];
        bias   = e5m2 ? E5M2_BIAS : E4M3_BIAS;
        emax   = e5m2 ? E5M2_EMAX : E4M3_EMAX;
        emin   = e5m2 ? E5M2_EMIN : E4M3_EMIN;
        inf8   = e5m2 ? E5M2_INF : E4M3_INF;
        nshift = e5m2 ? E5M2_NSHIFT : E4M3_NSHIFT;
        ef     = $signed({2'b00, exp8}) - FP32_BIAS + bias;
        ext    = 10'sd1 - ef;
        fe     = e5m2 ? in_operand[6:2] : {1'b0, in_operand[6:3]};
        fm     = e5m2 ? {in_operand[1:0], 1'b0} : in_operand[2:0];
        fe_max = e5m2 ? (fe == 5'd31) : (fe == 5'd15);

        data_next        = '0;
        data_next.narrow = narrow;
        data_next.e5m2   = e5m2;
        data_next.sign   = narrow ? in_operand[31] : in_operand[7];
        data_next.expo   = fe;
        data_next.man    = fm;
        data_next.sig    = {1'b1, frac};

        if (narrow) begin
            if (exp8 == 8'hff) begin
                data_next.done = 1'b1;
                data_next.word = (frac != FP32_FRAC0) ? {24'd0, FP8_NAN}
                                                      : {24'd0, in_operand[31], inf8[6:0]};
            end else if (exp8 == 8'h00 || ef < emin) begin
                // zero, FP32 subnormal, or below half the smallest subnormal
                data_next.done = 1'b1;
                data_next.word = {24'd0, in_operand[31], 7'd0};
            end else if (ef >= emax) begin
                data_next.done = 1'b1;
                data_next.word = {24'd0, in_operand[31], inf8[6:0]};
            end else if (ef > 10'sd0) begin
                data_next.base  = ef[4:0] - 5'd1;
                data_next.shamt = nshift;
            end else begin
                data_next.base  = 5'd0;
                data_next.shamt = nshift + ext[4:0];
            end
        end else begin
            if (fe_max) begin
                data_next.done = 1'b1;
                data_next.word = (fm != 3'd0) ? FP32_QNAN
                                              : {in_operand[7], FP32_INF[30:0]};
            end else if (fe == 5'd0 && fm == 3'd0) begin
                data_next.done = 1'b1;
                data_next.word = {in_operand[7], 31'd0};
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // A widening item left for later stages is never a signed zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !data_reg.done && !data_reg.narrow
        |-> (data_reg.expo != 5'd0 || data_reg.man != 3'd0))
        else $error("fp8c_decode: zero operand passed on as work");

endmodule

`default_nettype wire

// File: src/fp8c_align.sv
`default_nettype none

module fp8c_align
    import fp8c_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire dec_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output shf_t      out_data
);

    logic valid_reg;
    shf_t data_reg;
    shf_t data_next;

    always_comb begin
        logic [7:0]  ofs;
        logic [7:0]  e32;
        logic [2:0]  frac3;
        logic [1:0]  k;
        logic [4:0]  gpos;
        logic [23:0] mask;
        logic [23:0] shifted;

        ofs     = in_data.e5m2 ? E5M2_WOFS : E4M3_WOFS;
        gpos    = in_data.shamt - 5'd1;
        mask    = (24'd1 << gpos) - 24'd1;
        shifted = in_data.sig >> in_data.shamt;

        // leading one of the FP8 subnormal fraction
        priority if (in_data.man[2]) begin
            k = 2'd1;
        end else if (in_data.man[1]) begin
            k = 2'd2;
        end else begin
            k = 2'd3;
        end

        if (in_data.expo == 5'd0) begin
            e32   = ofs + 8'd1 - {6'd0, k};
            frac3 = 3'(in_data.man << k);
        end else begin
            e32   = ofs + {3'd0, in_data.expo};
            frac3 = in_data.man;
        end

        data_next        = '0;
        data_next.narrow = in_data.narrow;
        data_next.e5m2   = in_data.e5m2;
        data_next.sign   = in_data.sign;
        data_next.base   = in_data.base;
        data_next.q      = shifted[3:0];
        data_next.guard  = in_data.sig[gpos];
        data_next.sticky = |(in_data.sig & mask);

        if (in_data.done) begin
            data_next.done = 1'b1;
            data_next.word = in_data.word;
        end else if (!in_data.narrow) begin
            data_next.done = 1'b1;
            data_next.word = {in_data.sign, e32, frac3, 20'd0};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Narrowing work always shifts the significand by 20 to 24 places
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && !in_data.done && in_data.narrow
        |-> (in_data.shamt >= 5'd20 && in_data.shamt <= 5'd24))
        else $error("fp8c_align: shift amount out of range");

endmodule

`default_nettype wire

// File: src/fp8c_round.sv
`default_nettype none

module fp8c_round
    import fp8c_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire shf_t        in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_word
);

    logic        valid_reg;
    logic        narrow_reg;
    logic [31:0] word_reg;
    logic [31:0] word_next;

    always_comb begin
        logic       rup;
        logic [7:0] fld;
        logic [7:0] sum;
        logic [7:0] inf8;

        rup  = in_data.guard && (in_data.sticky || in_data.q[0]);
        fld  = in_data.e5m2 ? {1'b0, in_data.base, 2'b00} : {in_data.base, 3'b000};
        sum  = fld + {4'd0, in_data.q} + {7'd0, rup};
        inf8 = in_data.e5m2 ? E5M2_INF : E4M3_INF;

        if (in_data.done) begin
            word_next = in_data.word;
        end else if (sum >= inf8) begin
            // rounding carried into the reserved exponent
            word_next = {24'd0, in_data.sign, inf8[6:0]};
        end else begin
            word_next = {24'd0, in_data.sign, sum[6:0]};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg   <= word_next;
            narrow_reg <= in_data.narrow;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // FP8 results are zero-extended bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && narrow_reg |-> word_reg[31:8] == 24'd0)
        else $error("fp8c_round: narrowed result has upper bits set");

endmodule

`default_nettype wire

// File: src/fp8_fp32_converter_top.sv
// FP8 (E4M3 / E5M2) <-> FP32 format converter.
//
// Input channel (s_): one beat per conversion. s_tuser selects the action:
// E4M3 to FP32, E5M2 to FP32, FP32 to E4M3 or FP32 to E5M2. s_tdata holds
// the FP32 pattern, or the FP8 byte in bits 7..0 when widening.
// Result channel (m_): one beat per input beat, in order. m_tdata holds the
// FP32 pattern, or the FP8 byte zero-extended when narrowing.
//
// Pipeline: three register stages (decode, align, round/pack); m_tvalid and
// m_tdata come straight from the round/pack registers.
// Throughput: one beat per cycle while m_tready stays high. Each stage has
// its own valid bit and takes a new beat whenever it is empty or its
// contents move on, so bubbles are squeezed out while the output stalls.
// A stall on m_tready holds each full stage with no bubble ahead; s_tready drops once all
// three stages are full. Nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties all stages; there is no other
// state and no configuration.
`default_nettype none

module fp8_fp32_converter_top
    import fp8c_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] operand_bits
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] converted_bits
);

    // decode -> align
    logic dec_valid;
    logic dec_ready;
    dec_t dec_data;

    // align -> round
    logic shf_valid;
    logic shf_ready;
    shf_t shf_data;

    // Classify, catch specials and set up the shift
    fp8c_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (action_t'(s_tuser)),
        .in_operand (s_tdata),
        .out_valid  (dec_valid),
        .out_ready  (dec_ready),
        .out_data   (dec_data)
    );

    // Normalize FP8 subnormals; shift the FP32 significand, extract guard and sticky
    fp8c_align u_align (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (shf_valid),
        .out_ready (shf_ready),
        .out_data  (shf_data)
    );

    // Round to nearest even, saturate to infinity, drive the result beat
    fp8c_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (shf_valid),
        .in_ready  (shf_ready),
        .in_data   (shf_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata)
    );

    // A draining output never backs up to the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("fp8_fp32_converter_top: input stalled while output drains");

    // The input only stalls when every stage holds a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (dec_valid && shf_valid && m_tvalid))
        else $error("fp8_fp32_converter_top: input stalled with a bubble inside");

endmodule

`default_nettype wire
